FILE: design/gat_pkg.sv
// gat_pkg: shared types and constants of the gaussian adaptive threshold block
// request payload structs, register map, kernel weights
// no dependencies
`default_nettype none

package gat_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       frame_last;
    } out_item_t;

    typedef struct packed {
        logic       emit;
        logic       last;
        logic [8:0] rmask;
        logic [8:0] cmask;
    } ctl_t;

    typedef struct packed {
        logic       last;
        logic [7:0] center;
    } meta_t;

    localparam int APB_ADDR_W = 4;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX_VALUE    = 2'd2;
    localparam logic [1:0] REG_OFFSET       = 2'd3;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [7:0]  MAX_VALUE_RST    = 8'd255;
    localparam logic [8:0]  OFFSET_RST       = 9'd0;

    localparam int OUT_DEPTH = 32;
    localparam int OUT_PTR_W = 5;

    // weight by row distance, column distance, scaled by 10000
    localparam logic [8:0] GAUSS_W [0:4][0:4] = '{
        '{9'd478, 9'd413, 9'd267, 9'd128, 9'd46},
        '{9'd413, 9'd357, 9'd230, 9'd111, 9'd40},
        '{9'd267, 9'd230, 9'd149, 9'd72,  9'd26},
        '{9'd128, 9'd111, 9'd72,  9'd34,  9'd12},
        '{9'd46,  9'd40,  9'd26,  9'd12,  9'd4}
    };

endpackage

`default_nettype wire

FILE: design/gaussian_adaptive_threshold.sv
// gaussian_adaptive_threshold: streaming 9x9 gaussian adaptive threshold
// line buffer memory, window registers, weighted sum tree, pipelined divider
// depends on gat_pkg
//
//   channel  signals                          payload
//   item     item_valid / item_ready          in_item_t  {cmd, pixel}
//   result   result_valid / result_ready      out_item_t {out_pixel, frame_last}
//   config   psel penable pwrite paddr pwdata prdata pready
//
// one request per clock while the output queue has room; the result that a request
// produces leaves through a 32 entry output queue
// rate is set by the line buffer, one column read and one written per request
// reset clears positions, pipeline valids and queue; line buffer is not cleared
// requests are held off only when the output queue may overflow
`default_nettype none

module gaussian_adaptive_threshold
    import gat_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire in_item_t              item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output out_item_t                  result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WV_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HV_W   = $clog2(MAX_HEIGHT + 1);
    localparam int PEND_W = $clog2(4 * MAX_WIDTH + 6);
    localparam int CX_W   = WV_W + 4;
    localparam int RX_W   = HV_W + 4;
    localparam int OCC_W  = $clog2(OUT_DEPTH + 1);

    // configuration
    logic [10:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [7:0]  max_value_reg;
    logic [8:0]  offset_reg;
    logic        cfg_wr;
    logic        size_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign size_wr = cfg_wr && ((paddr[3:2] == REG_FRAME_WIDTH) ||
                                (paddr[3:2] == REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            max_value_reg    <= MAX_VALUE_RST;
            offset_reg       <= OFFSET_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[10:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[12:0];
                REG_MAX_VALUE:    max_value_reg    <= pwdata[7:0];
                REG_OFFSET:       offset_reg       <= pwdata[8:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = {21'd0, frame_width_reg};
            REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_reg};
            REG_MAX_VALUE:    prdata = {24'd0, max_value_reg};
            REG_OFFSET:       prdata = {23'd0, offset_reg};
        endcase
    end

    // clamped frame size
    logic [WV_W-1:0]   eff_w;
    logic [HV_W-1:0]   eff_h;
    logic [PEND_W-1:0] lag;

    always_comb
    begin
        if (frame_width_reg == 11'd0)
            eff_w = WV_W'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            eff_w = WV_W'(MAX_WIDTH);
        else
            eff_w = WV_W'(frame_width_reg);
        if (frame_height_reg == 13'd0)
            eff_h = HV_W'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            eff_h = HV_W'(MAX_HEIGHT);
        else
            eff_h = HV_W'(frame_height_reg);
        lag = PEND_W'({eff_w, 2'b00}) + PEND_W'(4);
    end

    // position tracking
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic              in_done_reg, in_done_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;

    logic acc, store, adv, emit, col_wrap, in_last, out_last;
    logic [PEND_W-1:0] pend_inc;
    ctl_t ctl0;

    assign item_ready = (occ_reg < OCC_W'(OUT_DEPTH));
    assign acc        = item_valid && item_ready;
    assign store      = acc && !in_done_reg && (item.cmd == CMD_PIXEL);
    assign adv        = acc && (in_done_reg || (item.cmd == CMD_PIXEL));
    assign pend_inc   = pend_reg + PEND_W'(1);
    assign emit       = acc && (in_done_reg || (store && (pend_inc > lag)));
    assign col_wrap   = (WV_W'(col_reg) + WV_W'(1)) == eff_w;
    assign in_last    = (HV_W'(in_row_reg) == eff_h - HV_W'(1)) && col_wrap;
    assign out_last   = (HV_W'(out_row_reg) == eff_h - HV_W'(1)) &&
                        ((WV_W'(out_col_reg) + WV_W'(1)) == eff_w);

    always_comb
    begin
        ctl0.emit  = emit;
        ctl0.last  = out_last;
        for (int k = 0; k < 9; k++)
        begin
            if (k > 4)
                ctl0.rmask[k] = RX_W'(out_row_reg) >= RX_W'(k - 4);
            else
                ctl0.rmask[k] = (RX_W'(out_row_reg) + RX_W'(4 - k)) < RX_W'(eff_h);
            if (k > 4)
                ctl0.cmask[k] = CX_W'(out_col_reg) >= CX_W'(k - 4);
            else
                ctl0.cmask[k] = (CX_W'(out_col_reg) + CX_W'(4 - k)) < CX_W'(eff_w);
        end
    end

    always_comb
    begin
        col_next     = col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        if (size_wr || (emit && out_last))
        begin
            col_next     = '0;
            in_row_next  = '0;
            in_done_next = 1'b0;
            out_col_next = '0;
            out_row_next = '0;
            pend_next    = '0;
        end
        else
        begin
            if (adv)
                col_next = col_wrap ? '0 : col_reg + COL_W'(1);
            if (store)
            begin
                if (in_last)
                    in_done_next = 1'b1;
                else if (col_wrap)
                    in_row_next = in_row_reg + ROW_W'(1);
            end
            if (store && !emit)
                pend_next = pend_inc;
            else if (!store && emit)
                pend_next = pend_reg - PEND_W'(1);
            if (emit)
            begin
                if ((WV_W'(out_col_reg) + WV_W'(1)) == eff_w)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                    out_col_next = out_col_reg + COL_W'(1);
            end
        end
    end

    logic res_acc;
    assign res_acc = result_valid && result_ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (emit && !res_acc)
            occ_next = occ_reg + OCC_W'(1);
        else if (!emit && res_acc)
            occ_next = occ_reg - OCC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            in_row_reg  <= '0;
            in_done_reg <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
            occ_reg     <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            in_row_reg  <= in_row_next;
            in_done_reg <= in_done_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
            occ_reg     <= occ_next;
        end
    end

    // line buffer: eight previous rows per column, newest in the low byte
    logic [63:0] lb_mem [0:MAX_WIDTH-1];
    logic [63:0] lb_rd_reg;
    logic [63:0] lb_word;
    logic [63:0] lb_wdata;

    logic             s1_adv_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic [7:0]       s1_pix_reg;
    ctl_t             s1_ctl_reg;

    logic             s2_adv_reg;
    logic [COL_W-1:0] s2_addr_reg;
    logic [63:0]      s2_wdata_reg;
    ctl_t             s2_ctl_reg;

    assign lb_word  = (s2_adv_reg && (s2_addr_reg == s1_addr_reg)) ? s2_wdata_reg : lb_rd_reg;
    assign lb_wdata = {lb_word[55:0], s1_pix_reg};

    always_ff @(posedge clk)
    begin
        lb_rd_reg <= lb_mem[col_reg];
        if (s1_adv_reg)
            lb_mem[s1_addr_reg] <= lb_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_adv_reg <= 1'b0;
            s1_ctl_reg <= '0;
            s2_adv_reg <= 1'b0;
            s2_ctl_reg <= '0;
        end
        else
        begin
            s1_adv_reg <= adv;
            s1_ctl_reg <= ctl0;
            s2_adv_reg <= s1_adv_reg;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= col_reg;
        s1_pix_reg   <= item.pixel;
        s2_addr_reg  <= s1_addr_reg;
        s2_wdata_reg <= lb_wdata;
    end

    // 9x9 window, row 0 newest, column 0 newest
    logic [7:0] win_reg [0:8][0:8];
    logic [7:0] col_pix [0:8];

    always_comb
    begin
        col_pix[0] = s1_pix_reg;
        for (int k = 1; k < 9; k++)
            col_pix[k] = lb_word[8*(k-1) +: 8];
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv_reg)
        begin
            for (int k = 0; k < 9; k++)
            begin
                for (int j = 8; j > 0; j--)
                    win_reg[k][j] <= win_reg[k][j-1];
                win_reg[k][0] <= col_pix[k];
            end
        end
    end

    // pixel sums and cell counts per weight class
    logic [9:0] gsum [0:4][0:4];
    logic [2:0] gcnt [0:4][0:4];

    always_comb
    begin
        int ak;
        int bj;
        for (int a = 0; a < 5; a++)
        begin
            for (int b = 0; b < 5; b++)
            begin
                gsum[a][b] = '0;
                gcnt[a][b] = '0;
            end
        end
        for (int k = 0; k < 9; k++)
        begin
            ak = (k < 4) ? 4 - k : k - 4;
            for (int j = 0; j < 9; j++)
            begin
                bj = (j < 4) ? 4 - j : j - 4;
                if (s2_ctl_reg.rmask[k] && s2_ctl_reg.cmask[j])
                begin
                    gsum[ak][bj] = gsum[ak][bj] + 10'(win_reg[k][j]);
                    gcnt[ak][bj] = gcnt[ak][bj] + 3'd1;
                end
            end
        end
    end

    logic       s3_vld_reg;
    logic [9:0] gsum_reg [0:4][0:4];
    logic [2:0] gcnt_reg [0:4][0:4];
    meta_t      s3_meta_reg;

    logic        s4_vld_reg;
    logic [18:0] vprod_reg [0:4][0:4];
    logic [11:0] wprod_reg [0:4][0:4];
    meta_t       s4_meta_reg;

    logic        s5_vld_reg;
    logic [21:0] vrow_reg [0:4];
    logic [13:0] wrow_reg [0:4];
    meta_t       s5_meta_reg;

    logic [21:0] vrow [0:4];
    logic [13:0] wrow [0:4];
    logic [21:0] vtot;
    logic [13:0] wtot;

    always_comb
    begin
        for (int a = 0; a < 5; a++)
        begin
            vrow[a] = '0;
            wrow[a] = '0;
            for (int b = 0; b < 5; b++)
            begin
                vrow[a] = vrow[a] + 22'(vprod_reg[a][b]);
                wrow[a] = wrow[a] + 14'(wprod_reg[a][b]);
            end
        end
        vtot = '0;
        wtot = '0;
        for (int a = 0; a < 5; a++)
        begin
            vtot = vtot + vrow_reg[a];
            wtot = wtot + wrow_reg[a];
        end
    end

    // restoring divider, one quotient bit per stage
    logic        dv_vld_reg  [0:8];
    logic [21:0] dv_rem_reg  [0:8];
    logic [13:0] dv_den_reg  [0:8];
    logic [7:0]  dv_q_reg    [0:8];
    meta_t       dv_meta_reg [0:8];

    logic [21:0] dv_sh   [0:7];
    logic        dv_take [0:7];

    always_comb
    begin
        for (int n = 0; n < 8; n++)
        begin
            dv_sh[n]   = {8'd0, dv_den_reg[n]} << (7 - n);
            dv_take[n] = dv_rem_reg[n] >= dv_sh[n];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            for (int n = 0; n < 9; n++)
                dv_vld_reg[n] <= 1'b0;
        end
        else
        begin
            s3_vld_reg    <= s2_adv_reg && s2_ctl_reg.emit;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            dv_vld_reg[0] <= s5_vld_reg;
            for (int n = 0; n < 8; n++)
                dv_vld_reg[n+1] <= dv_vld_reg[n];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 5; a++)
        begin
            for (int b = 0; b < 5; b++)
            begin
                gsum_reg[a][b]  <= gsum[a][b];
                gcnt_reg[a][b]  <= gcnt[a][b];
                vprod_reg[a][b] <= 19'(gsum_reg[a][b]) * 19'(GAUSS_W[a][b]);
                wprod_reg[a][b] <= 12'(gcnt_reg[a][b]) * 12'(GAUSS_W[a][b]);
            end
            vrow_reg[a] <= vrow[a];
            wrow_reg[a] <= wrow[a];
        end
        s3_meta_reg.last   <= s2_ctl_reg.last;
        s3_meta_reg.center <= win_reg[4][4];
        s4_meta_reg        <= s3_meta_reg;
        s5_meta_reg        <= s4_meta_reg;
        dv_rem_reg[0]      <= vtot;
        dv_den_reg[0]      <= wtot;
        dv_q_reg[0]        <= '0;
        dv_meta_reg[0]     <= s5_meta_reg;
        for (int n = 0; n < 8; n++)
        begin
            dv_rem_reg[n+1]  <= dv_take[n] ? dv_rem_reg[n] - dv_sh[n] : dv_rem_reg[n];
            dv_den_reg[n+1]  <= dv_den_reg[n];
            dv_q_reg[n+1]    <= {dv_q_reg[n][6:0], dv_take[n]};
            dv_meta_reg[n+1] <= dv_meta_reg[n];
        end
    end

    // threshold and output queue
    logic signed [10:0] thr;
    logic               above;
    out_item_t          res_new;

    assign thr   = $signed({3'b000, dv_q_reg[8]}) - $signed({{2{offset_reg[8]}}, offset_reg});
    assign above = $signed({3'b000, dv_meta_reg[8].center}) > thr;

    always_comb
    begin
        res_new.out_pixel  = above ? max_value_reg : 8'd0;
        res_new.frame_last = dv_meta_reg[8].last;
    end

    out_item_t            oq_mem [0:OUT_DEPTH-1];
    logic [OUT_PTR_W-1:0] oq_wr_reg;
    logic [OUT_PTR_W-1:0] oq_rd_reg;
    logic [OCC_W-1:0]     oq_cnt_reg, oq_cnt_next;

    always_ff @(posedge clk)
    begin
        if (dv_vld_reg[8])
            oq_mem[oq_wr_reg] <= res_new;
    end

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        if (dv_vld_reg[8] && !res_acc)
            oq_cnt_next = oq_cnt_reg + OCC_W'(1);
        else if (!dv_vld_reg[8] && res_acc)
            oq_cnt_next = oq_cnt_reg - OCC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (dv_vld_reg[8])
                oq_wr_reg <= oq_wr_reg + OUT_PTR_W'(1);
            if (res_acc)
                oq_rd_reg <= oq_rd_reg + OUT_PTR_W'(1);
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    assign result_valid = (oq_cnt_reg != '0);
    assign result       = oq_mem[oq_rd_reg];

endmodule

`default_nettype wire

FILE: tb/sv/gaussian_adaptive_threshold_tb.sv
// gaussian_adaptive_threshold_tb: self-checking bench for the adaptive threshold block
// directed table then random frames, results checked against a local pixel predictor
// depends on gat_pkg and gaussian_adaptive_threshold
`default_nettype none

module gaussian_adaptive_threshold_tb;
    import gat_pkg::*;

    localparam int MAXW = 1024;
    localparam int MAXH = 4096;
    localparam int SETTLE = 40;

    typedef struct {
        bit         is_cfg;
        logic [1:0] idx;
        logic [31:0] val;
        in_item_t   req;
        bit         typed;
        bit         has;
        out_item_t  exp;
    } row_t;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    in_item_t item;
    logic result_valid;
    logic result_ready;
    out_item_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    gaussian_adaptive_threshold u_top (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [7:0]  pix_mem [0:16*MAXW-1];
    int unsigned in_col, in_row, out_col, out_row;
    logic [10:0] cfg_width;
    logic [12:0] cfg_height;
    logic [7:0]  cfg_max;
    logic signed [8:0] cfg_offset;
    bit frame_done;

    out_item_t pending_q[$];
    int errors;
    int results_seen;
    int frames_seen;
    int useful_reqs;
    int hold_cycles;
    bit gaps_on;
    int burst_left;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #20_000_000;
        $display("timeout");
        $display("** gaussian_adaptive_threshold: FAILED **");
        $finish;
    end

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAXW) return MAXW;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height == 0) return 1;
        if (cfg_height > MAXH) return MAXH;
        return cfg_height;
    endfunction

    task automatic clear_positions();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic threshold_pixel(input int unsigned w, input int unsigned h,
                                   output out_item_t r);
        int unsigned vsum;
        int unsigned wsum;
        int unsigned wt;
        int rr;
        int cc;
        int thr;
        logic [7:0] center;
        vsum = 0;
        wsum = 0;
        for (int di = -4; di <= 4; di++)
        begin
            rr = int'(out_row) + di;
            if (rr < 0 || rr >= int'(h))
                continue;
            for (int dj = -4; dj <= 4; dj++)
            begin
                cc = int'(out_col) + dj;
                if (cc < 0 || cc >= int'(w))
                    continue;
                wt = GAUSS_W[di < 0 ? -di : di][dj < 0 ? -dj : dj];
                vsum += pix_mem[(rr & 15) * MAXW + cc] * wt;
                wsum += wt;
            end
        end
        center = pix_mem[(out_row & 15) * MAXW + out_col];
        thr = int'(vsum / wsum) - int'(cfg_offset);
        r.out_pixel = (int'(center) > thr) ? cfg_max : 8'd0;
        r.frame_last = (out_row == h - 1 && out_col == w - 1);
        if (r.frame_last)
        begin
            clear_positions();
            frame_done = 1'b1;
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    task automatic threshold_step(input in_item_t it, output bit has, output out_item_t r,
                                  output bit stored);
        int unsigned w;
        int unsigned h;
        w = eff_width();
        h = eff_height();
        has = 0;
        stored = 0;
        r = '0;
        if (in_row >= h || in_col >= w)
        begin
            if (out_row >= h || out_col >= w)
                clear_positions();
            else
            begin
                threshold_pixel(w, h, r);
                has = 1;
            end
            return;
        end
        if (it.cmd == CMD_DRAIN)
            return;
        pix_mem[(in_row & 15) * MAXW + in_col] = it.pixel;
        stored = 1;
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        if (in_row * w + in_col > out_row * w + out_col + 4 * w + 4)
        begin
            threshold_pixel(w, h, r);
            has = 1;
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %0d: %s got %0d expected %0d", errors, what, got, want);
    endtask

    // sender: call sites sit right after a posedge or at time zero
    task automatic send_request(in_item_t it, bit typed = 0, bit t_has = 0,
                                out_item_t t_exp = '0);
        bit has;
        bit stored;
        out_item_t r;
        @(negedge clk);
        if (gaps_on && burst_left <= 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (!item_ready);
        threshold_step(it, has, r, stored);
        if (has || stored)
            useful_reqs++;
        if (typed)
        begin
            has = t_has;
            r = t_exp;
        end
        if (has)
            pending_q.push_back(r);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:
            begin
                cfg_width = val[10:0];
                clear_positions();
            end
            REG_FRAME_HEIGHT:
            begin
                cfg_height = val[12:0];
                clear_positions();
            end
            REG_MAX_VALUE: cfg_max = val[7:0];
            default: cfg_offset = val[8:0];
        endcase
        frame_done = 0;
        @(posedge clk);
    endtask

    task automatic setup_frame(int w, int h, int mx, int off);
        wait_idle();
        apb_write(REG_FRAME_WIDTH, w);
        apb_write(REG_FRAME_HEIGHT, h);
        apb_write(REG_MAX_VALUE, mx);
        apb_write(REG_OFFSET, off);
    endtask

    // one frame of random content; cut < full size leaves it unfinished
    task automatic run_frame(int w, int h, int cut);
        in_item_t it;
        int base;
        bit smooth;
        setup_frame(w, h, $urandom_range(0, 255), $urandom_range(0, 511));
        gaps_on = $urandom_range(0, 3) != 0;
        smooth = $urandom_range(0, 1);
        base = $urandom_range(0, 255);
        for (int k = 0; k < cut; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request('{cmd: CMD_DRAIN, pixel: 8'($urandom)});
            if ($urandom_range(0, 15) == 0)
                base = $urandom_range(0, 255);
            it.cmd = CMD_PIXEL;
            if (smooth)
                it.pixel = 8'((base + $urandom_range(0, 40) < 20) ? 0 :
                              (base + $urandom_range(0, 40) - 20 > 255) ? 255 :
                              base + $urandom_range(0, 40) - 20);
            else
                it.pixel = 8'($urandom);
            send_request(it);
        end
        if (cut < int'(eff_width() * eff_height()))
            return;
        if ($urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            while (pending_q.size() != 0)
                @(posedge clk);
        end
        while (!frame_done)
        begin
            it.cmd = ($urandom_range(0, 4) == 0) ? CMD_PIXEL : CMD_DRAIN;
            it.pixel = 8'($urandom);
            send_request(it);
        end
        send_request('{cmd: CMD_DRAIN, pixel: 8'($urandom)});
    endtask

    // result side
    initial
    begin
        int rcount;
        int rmode;
        out_item_t want;
        result_ready = 1'b0;
        rcount = 0;
        rmode = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                results_seen++;
                if (pending_q.size() == 0)
                    report_mismatch("result with nothing pending, out_pixel", result.out_pixel, -1);
                else
                begin
                    want = pending_q.pop_front();
                    if (result.out_pixel !== want.out_pixel)
                        report_mismatch("out_pixel", result.out_pixel, want.out_pixel);
                    if (result.frame_last !== want.frame_last)
                        report_mismatch("frame_last", result.frame_last, want.frame_last);
                    if (want.frame_last)
                        frames_seen++;
                end
            end
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                result_ready <= 1'b0;
            end
            else
            begin
                rcount++;
                if (rcount % 64 == 0)
                    rmode = $urandom_range(0, 2);
                case (rmode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= 1'($urandom);
                    default: result_ready <= (rcount % 4 == 0);
                endcase
            end
        end
    end

    initial
    begin
        row_t dir[$];
        int random_start;
        item_valid = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        results_seen = 0;
        frames_seen = 0;
        useful_reqs = 0;
        hold_cycles = 0;
        gaps_on = 0;
        burst_left = 0;
        frame_done = 0;
        cfg_width = FRAME_WIDTH_RST;
        cfg_height = FRAME_HEIGHT_RST;
        cfg_max = MAX_VALUE_RST;
        cfg_offset = OFFSET_RST;
        clear_positions();
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // single pixel frames: the mean is the pixel itself
        dir.push_back('{1, REG_FRAME_WIDTH, 1, '0, 0, 0, '0});
        dir.push_back('{1, REG_FRAME_HEIGHT, 1, '0, 0, 0, '0});
        dir.push_back('{0, 0, 0, '{CMD_DRAIN, 8'd9}, 1, 0, '0});
        dir.push_back('{0, 0, 0, '{CMD_PIXEL, 8'd255}, 1, 0, '0});
        dir.push_back('{0, 0, 0, '{CMD_PIXEL, 8'd7}, 1, 1, '{8'd0, 1'b1}});
        dir.push_back('{0, 0, 0, '{CMD_PIXEL, 8'd0}, 1, 0, '0});
        dir.push_back('{0, 0, 0, '{CMD_DRAIN, 8'd0}, 1, 1, '{8'd0, 1'b1}});
        dir.push_back('{1, REG_OFFSET, 255, '0, 0, 0, '0});
        dir.push_back('{0, 0, 0, '{CMD_PIXEL, 8'd0}, 1, 0, '0});
        dir.push_back('{0, 0, 0, '{CMD_DRAIN, 8'd0}, 1, 1, '{8'd255, 1'b1}});
        dir.push_back('{1, REG_MAX_VALUE, 0, '0, 0, 0, '0});
        dir.push_back('{0, 0, 0, '{CMD_PIXEL, 8'd255}, 1, 0, '0});
        dir.push_back('{0, 0, 0, '{CMD_DRAIN, 8'd0}, 1, 1, '{8'd0, 1'b1}});
        dir.push_back('{1, REG_OFFSET, 32'h101, '0, 0, 0, '0});
        dir.push_back('{1, REG_MAX_VALUE, 170, '0, 0, 0, '0});
        dir.push_back('{0, 0, 0, '{CMD_PIXEL, 8'd255}, 1, 0, '0});
        dir.push_back('{0, 0, 0, '{CMD_DRAIN, 8'd0}, 1, 1, '{8'd0, 1'b1}});
        // zero sizes clamp to one, then a small 3x2 frame
        dir.push_back('{1, REG_FRAME_WIDTH, 0, '0, 0, 0, '0});
        dir.push_back('{1, REG_FRAME_HEIGHT, 0, '0, 0, 0, '0});
        dir.push_back('{0, 0, 0, '{CMD_PIXEL, 8'd128}, 0, 0, '0});
        dir.push_back('{0, 0, 0, '{CMD_DRAIN, 8'd0}, 0, 0, '0});
        dir.push_back('{1, REG_FRAME_WIDTH, 3, '0, 0, 0, '0});
        dir.push_back('{1, REG_FRAME_HEIGHT, 2, '0, 0, 0, '0});
        dir.push_back('{1, REG_OFFSET, 32'h100, '0, 0, 0, '0});
        for (int k = 0; k < 6; k++)
            dir.push_back('{0, 0, 0, '{CMD_PIXEL, (k % 2) ? 8'd255 : 8'd0}, 0, 0, '0});
        for (int k = 0; k < 7; k++)
            dir.push_back('{0, 0, 0, '{CMD_DRAIN, 8'd0}, 0, 0, '0});

        foreach (dir[i])
        begin
            if (dir[i].is_cfg)
            begin
                wait_idle();
                apb_write(dir[i].idx, dir[i].val);
            end
            else
                send_request(dir[i].req, dir[i].typed, dir[i].has, dir[i].exp);
        end

        // oversized width clamps to the maximum, left unfinished and aborted
        run_frame(2047, 1, 100);
        // tall frames with a long receiver stall that fills the block
        hold_cycles = 400;
        run_frame(1, 8191, 120);
        run_frame(1, 4096, 40);

        random_start = useful_reqs;
        while (useful_reqs - random_start < 200)
        begin
            int w;
            int h;
            int n;
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 16);
            h = $urandom_range(1, 10);
            n = w * h;
            run_frame(w, h, ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : n);
        end

        wait_idle();
        $display("checked %0d results over %0d completed frames, %0d useful requests",
                 results_seen, frames_seen, useful_reqs);
        $display("covered size clamps, extreme offsets and levels, aborts and a long stall");
        if (errors == 0)
            $display("** gaussian_adaptive_threshold: PASSED **");
        else
            $display("** gaussian_adaptive_threshold: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
